// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define KDSLP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kdslp assertion failed");

// next-cycle implication
`define KDSLP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kdslp assertion failed");

`endif

// ----- rtl/kdslp_pkg.sv -----
// ----------------------------------------------------------------------------
// kdslp_pkg
// shared types, constants and helpers of the key debounce / press detector
// ----------------------------------------------------------------------------
package kdslp_pkg;

  // key count and field widths
  localparam int unsigned NUM_KEYS  = 3;
  localparam int unsigned RAW_W     = 3;
  localparam int unsigned EV_W      = 3;
  localparam int unsigned DB_W      = 8;
  localparam int unsigned HOLD_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESSED_LEVEL  = 2'd2;

  // register reset values
  localparam logic [DB_W-1:0]   DEBOUNCE_RST = 8'd2;
  localparam logic [HOLD_W-1:0] LONG_RST     = 16'd40;

  // command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // event codes
  localparam logic [EV_W-1:0] EV_NONE = 3'd0;

  typedef struct packed {
    logic [DB_W-1:0]   debounce_ticks;
    logic [HOLD_W-1:0] long_ticks;
    logic              pressed_level;
  } cfg_t;

  typedef struct packed {
    logic short_ev;
    logic long_ev;
  } lane_ev_t;

  // event code for key k (0 based): short 2k+1, long 2k+2
  function automatic logic [EV_W-1:0] ev_code(input int unsigned k, input logic is_long);
    ev_code = EV_W'(2 * k + 1) + EV_W'(is_long);
  endfunction

endpackage

// ----- rtl/kdslp_lane.sv -----
// ----------------------------------------------------------------------------
// kdslp_lane
// per-key debounce filter, hold counter and short/long press detection
// ----------------------------------------------------------------------------
module kdslp_lane (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick,
  input  logic              raw_level,
  input  kdslp_pkg::cfg_t   cfg,
  output kdslp_pkg::lane_ev_t ev
);
  import kdslp_pkg::*;

  logic              stable_r, stable_nxt;
  logic              last_raw_r, last_raw_nxt;
  logic              long_rep_r, long_rep_nxt;
  logic [DB_W-1:0]   db_cnt_r, db_cnt_nxt;
  logic [HOLD_W-1:0] hold_r, hold_nxt;
  logic              now_pressed;
  logic [HOLD_W-1:0] hold_inc;

  assign now_pressed = (raw_level == cfg.pressed_level);
  assign hold_inc    = (hold_r != HOLD_MAX) ? hold_r + HOLD_W'(1) : hold_r;

  // next state for one tick
  always_comb begin
    stable_nxt   = stable_r;
    last_raw_nxt = last_raw_r;
    long_rep_nxt = long_rep_r;
    db_cnt_nxt   = db_cnt_r;
    hold_nxt     = hold_r;
    ev           = '0;
    if (now_pressed != last_raw_r) begin
      // raw change restarts the debounce count
      last_raw_nxt = now_pressed;
      db_cnt_nxt   = '0;
    end else if (db_cnt_r < cfg.debounce_ticks) begin
      db_cnt_nxt = db_cnt_r + DB_W'(1);
    end else if (now_pressed != stable_r) begin
      // new level accepted
      stable_nxt   = now_pressed;
      hold_nxt     = '0;
      long_rep_nxt = 1'b0;
      ev.short_ev  = !now_pressed && !long_rep_r;
    end else if (stable_r) begin
      // held: saturating count, one long event
      hold_nxt = hold_inc;
      if (!long_rep_r && (hold_inc >= cfg.long_ticks)) begin
        long_rep_nxt = 1'b1;
        ev.long_ev   = 1'b1;
      end
    end
  end

  // state registers, updated on ticks only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r   <= 1'b0;
      last_raw_r <= 1'b0;
      long_rep_r <= 1'b0;
      db_cnt_r   <= '0;
      hold_r     <= '0;
    end else if (tick) begin
      stable_r   <= stable_nxt;
      last_raw_r <= last_raw_nxt;
      long_rep_r <= long_rep_nxt;
      db_cnt_r   <= db_cnt_nxt;
      hold_r     <= hold_nxt;
    end
  end

endmodule

// ----- rtl/kdslp_merge.sv -----
// ----------------------------------------------------------------------------
// kdslp_merge
// priority merge of lane events into the pending slot, and the output register
// ----------------------------------------------------------------------------
module kdslp_merge (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_accept,
  input  logic                     in_command,
  input  kdslp_pkg::lane_ev_t      lane_ev [kdslp_pkg::NUM_KEYS],
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic [kdslp_pkg::EV_W-1:0] out_event_res
);
  import kdslp_pkg::*;

  logic [EV_W-1:0] pending_r, pending_nxt;
  logic [EV_W-1:0] out_ev_r, out_ev_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [EV_W-1:0] tick_ev;
  logic            found;

  // lowest numbered key wins
  always_comb begin
    tick_ev = EV_NONE;
    found   = 1'b0;
    for (int unsigned k = 0; k < NUM_KEYS; k++) begin
      if (!found && (lane_ev[k].short_ev || lane_ev[k].long_ev)) begin
        tick_ev = ev_code(k, lane_ev[k].long_ev);
        found   = 1'b1;
      end
    end
  end

  // slot update and result word
  always_comb begin
    pending_nxt   = pending_r;
    out_ev_nxt    = out_ev_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
      if (in_command == CMD_READ) begin
        out_ev_nxt  = pending_r;
        pending_nxt = EV_NONE;
      end else begin
        pending_nxt = (pending_r != EV_NONE) ? pending_r : tick_ev;
        out_ev_nxt  = pending_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= EV_NONE;
      out_valid_r <= 1'b0;
    end else begin
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    out_ev_r <= out_ev_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_event_res = out_ev_r;

endmodule

// ----- rtl/key_debounce_short_long_press.sv -----
// ----------------------------------------------------------------------------
// key_debounce_short_long_press
// three-key debouncer with short and long press events in a single slot
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   cfg     | cfg_we, cfg_index, cfg_wdata            | in
//   in      | in_valid, in_stall, in_command, in_raw_levels | in word
//   out     | out_valid, out_stall, out_event_res     | out word
//
// one word accepted per cycle while in_stall is low; its result word is shown the next cycle
// every key has its own lane, all lanes advance in the same cycle
// in_stall is high only while the output register is full and stalled
// synchronous active-low reset clears all key state and slot
// ----------------------------------------------------------------------------
module key_debounce_short_long_press (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [kdslp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kdslp_pkg::CFG_DAT_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_command,
  input  logic [kdslp_pkg::RAW_W-1:0]         in_raw_levels,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [kdslp_pkg::EV_W-1:0]          out_event_res
);
  import kdslp_pkg::*;

  cfg_t     cfg_r;
  logic     in_accept;
  logic     tick;
  lane_ev_t lane_ev [NUM_KEYS];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks <= DEBOUNCE_RST;
      cfg_r.long_ticks     <= LONG_RST;
      cfg_r.pressed_level  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE_TICKS: cfg_r.debounce_ticks <= cfg_wdata[DB_W-1:0];
        CFG_LONG_TICKS:     cfg_r.long_ticks     <= cfg_wdata[HOLD_W-1:0];
        CFG_PRESSED_LEVEL:  cfg_r.pressed_level  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign tick      = in_accept && (in_command == CMD_TICK);

  // one lane per key
  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
    kdslp_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .tick      (tick),
      .raw_level (in_raw_levels[g]),
      .cfg       (cfg_r),
      .ev        (lane_ev[g])
    );
  end

  // merge and output register
  kdslp_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_accept     (in_accept),
    .in_command    (in_command),
    .lane_ev       (lane_ev),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_event_res (out_event_res)
  );

endmodule

// ----- rtl/kdslp_checker.sv -----
// ----------------------------------------------------------------------------
// kdslp_checker
// port-level checks of the key debounce / press detector
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kdslp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            in_command,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [kdslp_pkg::EV_W-1:0]      out_event_res
);
  import kdslp_pkg::*;

  logic rd_acc;

  // read word accepted this cycle
  assign rd_acc = in_valid && !in_stall && (in_command == CMD_READ);

  // every accepted word gives a result word the next cycle
  `KDSLP_ASSERT_NXT(a_accept_gives_result, in_valid && !in_stall, out_valid)

  // input stalls only behind a full, stalled output register
  `KDSLP_ASSERT_IMP(a_stall_only_when_full, in_stall, out_valid && out_stall)

  // event codes stay in range
  `KDSLP_ASSERT_IMP(a_event_range, out_valid, out_event_res <= EV_W'(6))

  // a read right after a read finds the slot empty
  `KDSLP_ASSERT_NXT(a_read_clears, rd_acc && $past(rd_acc), out_event_res == EV_NONE)

  // a stalled result word holds
  `KDSLP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_event_res))

endmodule

bind key_debounce_short_long_press kdslp_checker u_kdslp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_command    (in_command),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_event_res (out_event_res)
);
